// ===== rtl/qat_pkg.sv =====
// Shared types, character codes and helpers for the quoted argument tokenizer.
`timescale 1ns / 1ps

package qat_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ResMax = 3;  // most results one item can cause
  localparam int unsigned CntW   = $clog2(ResMax + 1);

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_TEND = 2'd1,
    KIND_OK   = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

  typedef enum logic [11:0] {
    MODE_SKIP    = 12'b0000_0000_0001,
    MODE_PLAIN   = 12'b0000_0000_0010,
    MODE_DQ      = 12'b0000_0000_0100,
    MODE_DQ_ESC  = 12'b0000_0000_1000,
    MODE_DQ_X    = 12'b0000_0001_0000,
    MODE_DQ_XH_L = 12'b0000_0010_0000,
    MODE_DQ_XH_U = 12'b0000_0100_0000,
    MODE_DQ_END  = 12'b0000_1000_0000,
    MODE_SQ      = 12'b0001_0000_0000,
    MODE_SQ_BS   = 12'b0010_0000_0000,
    MODE_SQ_END  = 12'b0100_0000_0000,
    MODE_DISCARD = 12'b1000_0000_0000
  } mode_e;

  typedef struct packed {
    kind_e             kind;
    logic [CharW-1:0]  ch;
  } result_t;

  typedef struct packed {
    logic [CntW-1:0]           cnt;
    result_t [ResMax-1:0]      ent;
  } bundle_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChLf    = 8'h0A;
  localparam logic [CharW-1:0] ChVt    = 8'h0B;
  localparam logic [CharW-1:0] ChFf    = 8'h0C;
  localparam logic [CharW-1:0] ChCr    = 8'h0D;
  localparam logic [CharW-1:0] ChBs    = 8'h08;
  localparam logic [CharW-1:0] ChBel   = 8'h07;
  localparam logic [CharW-1:0] ChDq    = 8'h22;
  localparam logic [CharW-1:0] ChSq    = 8'h27;
  localparam logic [CharW-1:0] ChBsl   = 8'h5C;
  localparam logic [CharW-1:0] ChN     = 8'h6E;
  localparam logic [CharW-1:0] ChR     = 8'h72;
  localparam logic [CharW-1:0] ChT     = 8'h74;
  localparam logic [CharW-1:0] ChB     = 8'h62;
  localparam logic [CharW-1:0] ChA     = 8'h61;
  localparam logic [CharW-1:0] ChX     = 8'h78;
  localparam logic [CharW-1:0] Ch0     = 8'h30;
  localparam logic [CharW-1:0] Ch9     = 8'h39;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpF   = 8'h46;
  localparam logic [CharW-1:0] ChLoF   = 8'h66;

  function automatic logic blank_any(input logic [CharW-1:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic logic hex_upper(input logic [CharW-1:0] c);
    return (c >= ChUpA) && (c <= ChUpF);
  endfunction

  function automatic hex_t hex_value(input logic [CharW-1:0] c);
    hex_t h;
    logic [CharW-1:0] d;
    h = '0;
    d = '0;
    if (c >= Ch0 && c <= Ch9) begin
      d = c - Ch0;
      h.ok = 1'b1;
    end else if (c >= ChA && c <= ChLoF) begin
      d = c - ChA + 8'd10;
      h.ok = 1'b1;
    end else if (c >= ChUpA && c <= ChUpF) begin
      d = c - ChUpA + 8'd10;
      h.ok = 1'b1;
    end
    h.val = d[3:0];
    return h;
  endfunction

  function automatic result_t make_res(input kind_e k, input logic [CharW-1:0] c);
    result_t r;
    r.kind = k;
    r.ch   = (k == KIND_BYTE) ? c : '0;
    return r;
  endfunction

endpackage

// ===== rtl/qat_parse.sv =====
// Parse state and per-item decode: mode update and the results of one item.
`timescale 1ns / 1ps

module qat_parse (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic [qat_pkg::CharW-1:0]   char_i,
  input  logic                        line_end_i,
  output qat_pkg::bundle_t            bundle_o
);
  import qat_pkg::*;

  mode_e             mode_q, mode_d;
  logic [3:0]        hex_q, hex_d;
  logic              eol;
  logic [CntW-1:0]   n;
  result_t [ResMax-1:0] ent;
  hex_t              hv;
  mode_e             dq_mode, sq_mode;
  logic              dq_emit, sq_emit;
  logic [CharW-1:0]  held_ch;

  assign eol = line_end_i || (char_i == '0);
  assign hv  = hex_value(char_i);

  // Next mode and emit flag for a byte inside a double or single quoted region
  always_comb begin
    dq_emit = 1'b0;
    if (char_i == ChBsl) begin
      dq_mode = MODE_DQ_ESC;
    end else if (char_i == ChDq) begin
      dq_mode = MODE_DQ_END;
    end else begin
      dq_mode = MODE_DQ;
      dq_emit = 1'b1;
    end
    sq_emit = 1'b0;
    if (char_i == ChBsl) begin
      sq_mode = MODE_SQ_BS;
    end else if (char_i == ChSq) begin
      sq_mode = MODE_SQ_END;
    end else begin
      sq_mode = MODE_SQ;
      sq_emit = 1'b1;
    end
  end

  // Pending first hex digit as the character it came from
  always_comb begin
    if (hex_q < 4'd10) begin
      held_ch = Ch0 + {4'd0, hex_q};
    end else if (mode_q == MODE_DQ_XH_U) begin
      held_ch = ChUpA + {4'd0, hex_q} - 8'd10;
    end else begin
      held_ch = ChA + {4'd0, hex_q} - 8'd10;
    end
  end

  always_comb begin
    n      = '0;
    ent    = '0;
    mode_d = mode_q;
    hex_d  = hex_q;
    if (eol) begin
      unique case (mode_q)
        MODE_SKIP: begin
          ent[n] = make_res(KIND_OK, '0); n = n + 1'b1;
        end
        MODE_PLAIN, MODE_DQ_END, MODE_SQ_END: begin
          ent[n] = make_res(KIND_TEND, '0); n = n + 1'b1;
          ent[n] = make_res(KIND_OK, '0);   n = n + 1'b1;
        end
        MODE_DQ_X: begin
          ent[n] = make_res(KIND_BYTE, ChX); n = n + 1'b1;
          ent[n] = make_res(KIND_ERR, '0);   n = n + 1'b1;
        end
        MODE_DQ_XH_L, MODE_DQ_XH_U: begin
          ent[n] = make_res(KIND_BYTE, ChX);     n = n + 1'b1;
          ent[n] = make_res(KIND_BYTE, held_ch); n = n + 1'b1;
          ent[n] = make_res(KIND_ERR, '0);       n = n + 1'b1;
        end
        MODE_SQ_BS: begin
          ent[n] = make_res(KIND_BYTE, ChBsl); n = n + 1'b1;
          ent[n] = make_res(KIND_ERR, '0);     n = n + 1'b1;
        end
        MODE_DISCARD: ;
        default: begin
          ent[n] = make_res(KIND_ERR, '0); n = n + 1'b1;
        end
      endcase
      mode_d = MODE_SKIP;
    end else begin
      unique case (mode_q)
        MODE_SKIP, MODE_PLAIN: begin
          if (mode_q == MODE_SKIP && blank_any(char_i)) begin
            mode_d = MODE_SKIP;
          end else if (char_i == ChSpace || char_i == ChTab ||
                       char_i == ChLf || char_i == ChCr) begin
            ent[n] = make_res(KIND_TEND, '0); n = n + 1'b1;
            mode_d = MODE_SKIP;
          end else if (char_i == ChDq) begin
            mode_d = MODE_DQ;
          end else if (char_i == ChSq) begin
            mode_d = MODE_SQ;
          end else begin
            ent[n] = make_res(KIND_BYTE, char_i); n = n + 1'b1;
            mode_d = MODE_PLAIN;
          end
        end
        MODE_DQ: begin
          if (dq_emit) begin
            ent[n] = make_res(KIND_BYTE, char_i); n = n + 1'b1;
          end
          mode_d = dq_mode;
        end
        MODE_DQ_ESC: begin
          mode_d = MODE_DQ;
          case (char_i)
            ChX: mode_d = MODE_DQ_X;
            ChN: begin ent[n] = make_res(KIND_BYTE, ChLf);   n = n + 1'b1; end
            ChR: begin ent[n] = make_res(KIND_BYTE, ChCr);   n = n + 1'b1; end
            ChT: begin ent[n] = make_res(KIND_BYTE, ChTab);  n = n + 1'b1; end
            ChB: begin ent[n] = make_res(KIND_BYTE, ChBs);   n = n + 1'b1; end
            ChA: begin ent[n] = make_res(KIND_BYTE, ChBel);  n = n + 1'b1; end
            default: begin ent[n] = make_res(KIND_BYTE, char_i); n = n + 1'b1; end
          endcase
        end
        MODE_DQ_X: begin
          if (hv.ok) begin
            hex_d  = hv.val;
            mode_d = hex_upper(char_i) ? MODE_DQ_XH_U : MODE_DQ_XH_L;
          end else begin
            ent[n] = make_res(KIND_BYTE, ChX); n = n + 1'b1;
            if (dq_emit) begin
              ent[n] = make_res(KIND_BYTE, char_i); n = n + 1'b1;
            end
            mode_d = dq_mode;
          end
        end
        MODE_DQ_XH_L, MODE_DQ_XH_U: begin
          if (hv.ok) begin
            ent[n] = make_res(KIND_BYTE, {hex_q, hv.val}); n = n + 1'b1;
            mode_d = MODE_DQ;
          end else begin
            ent[n] = make_res(KIND_BYTE, ChX);     n = n + 1'b1;
            ent[n] = make_res(KIND_BYTE, held_ch); n = n + 1'b1;
            if (dq_emit) begin
              ent[n] = make_res(KIND_BYTE, char_i); n = n + 1'b1;
            end
            mode_d = dq_mode;
          end
        end
        MODE_SQ: begin
          if (sq_emit) begin
            ent[n] = make_res(KIND_BYTE, char_i); n = n + 1'b1;
          end
          mode_d = sq_mode;
        end
        MODE_SQ_BS: begin
          if (char_i == ChSq) begin
            ent[n] = make_res(KIND_BYTE, ChSq); n = n + 1'b1;
            mode_d = MODE_SQ;
          end else begin
            ent[n] = make_res(KIND_BYTE, ChBsl); n = n + 1'b1;
            if (sq_emit) begin
              ent[n] = make_res(KIND_BYTE, char_i); n = n + 1'b1;
            end
            mode_d = sq_mode;
          end
        end
        MODE_DQ_END, MODE_SQ_END: begin
          if (blank_any(char_i)) begin
            ent[n] = make_res(KIND_TEND, '0); n = n + 1'b1;
            mode_d = MODE_SKIP;
          end else begin
            ent[n] = make_res(KIND_ERR, '0); n = n + 1'b1;
            mode_d = MODE_DISCARD;
          end
        end
        MODE_DISCARD: ;
        default: mode_d = MODE_DISCARD;
      endcase
    end
  end

  assign bundle_o.cnt = n;
  assign bundle_o.ent = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SKIP;
      hex_q  <= '0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      hex_q  <= hex_d;
    end
  end

endmodule

// ===== rtl/qat_outbuf.sv =====
// Result register: holds the results of one item and hands them out in order.
`timescale 1ns / 1ps

module qat_outbuf (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  qat_pkg::bundle_t           bundle_i,
  output logic                       free_o,
  output logic                       tvalid_o,
  input  logic                       tready_i,
  output logic [qat_pkg::CharW-1:0]  tdata_o,
  output logic [1:0]                 tuser_o,
  output logic                       tlast_o
);
  import qat_pkg::*;

  logic [CntW-1:0]       cnt_q;
  result_t [ResMax-1:0]  ent_q;
  logic                  pop;

  assign tvalid_o = (cnt_q != '0);
  assign pop      = tvalid_o && tready_i;
  assign tlast_o  = (cnt_q == CntW'(1));
  assign tdata_o  = ent_q[0].ch;
  assign tuser_o  = ent_q[0].kind;
  // Free when empty or when the final item goes out this cycle
  assign free_o   = !tvalid_o || (tlast_o && tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= bundle_i.cnt;
    end else if (pop) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Shift toward slot 0 as each item leaves
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= bundle_i.ent;
    end else if (pop) begin
      for (int i = 0; i < ResMax - 1; i++) begin
        ent_q[i] <= ent_q[i+1];
      end
      ent_q[ResMax-1] <= '0;
    end
  end

endmodule

// ===== rtl/quoted_argument_tokenizer_top.sv =====
// Top level of the quoted argument tokenizer: input register, parser, result register.
//
//  channel  dir  tdata            tuser     tlast
//  s_axis   in   [7:0] char_in    -         line_end
//  m_axis   out  [7:0] char_out   [1:0] kind last
//
//  An item that yields zero or one result leaves the input register once there is room,
//  so these stream at one per clock while m_axis is ready. An item that yields N results
//  (at most three) holds the result register until all N are out; output bandwidth of
//  one result per clock sets the rate. Reset clears the parse mode to blank skipping and
//  empties both registers. Input is taken while a result still waits on m_axis.
`timescale 1ns / 1ps

module quoted_argument_tokenizer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] char_out
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast
);
  import qat_pkg::*;

  logic              in_valid_q;
  logic [CharW-1:0]  in_char_q;
  logic              in_eol_q;
  bundle_t           bundle;
  logic              buf_free;
  logic              step_fire;
  logic              load;

  // Items with no result need no room in the result register
  assign step_fire     = in_valid_q && (buf_free || (bundle.cnt == '0));
  assign load          = step_fire && (bundle.cnt != '0);
  assign s_axis_tready = !in_valid_q || step_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
      in_eol_q  <= s_axis_tlast;
    end
  end

  qat_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (step_fire),
    .char_i     (in_char_q),
    .line_end_i (in_eol_q),
    .bundle_o   (bundle)
  );

  qat_outbuf u_outbuf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .bundle_i (bundle),
    .free_o   (buf_free),
    .tvalid_o (m_axis_tvalid),
    .tready_i (m_axis_tready),
    .tdata_o  (m_axis_tdata),
    .tuser_o  (m_axis_tuser),
    .tlast_o  (m_axis_tlast)
  );

  // Never overwrite results that are still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!m_axis_tvalid || (m_axis_tlast && m_axis_tready)))
    else $error("result register loaded while holding items");

  // A line status closes the results of its item
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_OK || m_axis_tuser == KIND_ERR))
      |-> m_axis_tlast)
    else $error("line status not last of its item");

  // Only token bytes carry data
  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != KIND_BYTE) |-> (m_axis_tdata == '0))
    else $error("nonzero data on a non-byte item");

  // An accepted item that is stuck in the input register waits on a full result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !step_fire) |-> (m_axis_tvalid && !buf_free))
    else $error("input stalled without a full result register");

endmodule
